@@ design/mkvc_pkg.sv @@
package mkvc_pkg;

    localparam int PIX_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 38;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNELS_IN_USE = 3'd4;

    localparam logic CMD_COEF  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

endpackage

@@ design/mkvc_ram.sv @@
module mkvc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/mkvc_cell.sv @@
module mkvc_cell #(
    parameter int KERNELS = 8,
    parameter int KIW     = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic signed [mkvc_pkg::PIX_W-1:0] pix,
    input  logic                              coef_we,
    input  logic [KIW-1:0]                    coef_kidx,
    input  logic signed [mkvc_pkg::PIX_W-1:0] coef_val,
    input  logic                              tok_valid_in,
    input  logic [KIW-1:0]                    tok_kidx_in,
    input  logic signed [mkvc_pkg::ACC_W-1:0] psum_in,
    output logic                              tok_valid_out,
    output logic [KIW-1:0]                    tok_kidx_out,
    output logic signed [mkvc_pkg::ACC_W-1:0] psum_out
);

    import mkvc_pkg::*;

    logic signed [PIX_W-1:0]  coef_reg [KERNELS];
    logic                     mid_valid_reg;
    logic [KIW-1:0]           mid_kidx_reg;
    logic signed [ACC_W-1:0]  mid_psum_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     out_valid_reg;
    logic [KIW-1:0]           out_kidx_reg;
    logic signed [ACC_W-1:0]  out_psum_reg;

    // this tap's coefficient for every kernel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KERNELS; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (coef_we)
        begin
            coef_reg[coef_kidx] <= coef_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mid_valid_reg <= tok_valid_in;
            out_valid_reg <= mid_valid_reg;
        end
    end

    // multiply in the first stage, add into the passing sum in the second
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mid_kidx_reg <= tok_kidx_in;
            mid_psum_reg <= psum_in;
            prod_reg     <= pix * coef_reg[tok_kidx_in];
            out_kidx_reg <= mid_kidx_reg;
            out_psum_reg <= mid_psum_reg
                            + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    assign tok_valid_out = out_valid_reg;
    assign tok_kidx_out  = out_kidx_reg;
    assign psum_out      = out_psum_reg;

endmodule

@@ design/multi_kernel_valid_conv2d.sv @@
// Multi-kernel valid-region 2-D correlation over a raster pixel stream.
// Input channel (in_valid/in_ready): each word is a coefficient write
// (command 0) or the next pixel of the frame (command 1). Output channel
// (out_valid/out_ready): one word per kernel in use for every pixel that
// completes a full window, kernel 0 first, last set on the final kernel.
// Config port: cfg_write/cfg_index/cfg_data, one register per cycle.
// After reset the block clears its line memories with in_ready low. A
// coefficient write leaves the block idle and ready for the next word. A
// pixel is accepted in idle, then the read state reads the line memories
// and loads the window; if it yields results, kernels enter a chain of
// MAX_KERNEL_DIM^2 tap cells one per cycle while the output is not stalled,
// each cell two stages deep, and each result passes through both stages of
// every cell and the output word register.
// The next word is taken once all results of a pixel are delivered.
// When out_ready is low while an output word waits, the whole chain holds;
// nothing is dropped.
module multi_kernel_valid_conv2d #(
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_KERNEL_DIM = 7,
    parameter int MAX_KERNELS    = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [mkvc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mkvc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   command,
    input  logic signed [15:0]                     pixel,
    input  logic [2:0]                             coef_kernel,
    input  logic [2:0]                             coef_row,
    input  logic [2:0]                             coef_col,
    input  logic signed [15:0]                     coef_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [2:0]                             kernel_index,
    output logic [9:0]                             out_row,
    output logic [9:0]                             out_col,
    output logic signed [37:0]                     conv_value,
    output logic                                   last
);

    import mkvc_pkg::*;

    localparam int D     = MAX_KERNEL_DIM;
    localparam int TAPS  = D * D;
    localparam int LINES = (D > 1) ? D - 1 : 1;
    localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int DW    = (D > 1) ? $clog2(D) : 1;
    localparam int DBW   = $clog2(D + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WBW   = $clog2(MAX_WIDTH + 1);
    localparam int KIW   = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;
    localparam int KBW   = $clog2(MAX_KERNELS + 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_INJECT = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;

    logic [10:0] fw_reg;
    logic [10:0] fh_reg;
    logic [2:0]  kh_reg;
    logic [2:0]  kw_reg;
    logic [3:0]  nk_reg;

    logic [WBW-1:0] fw_eff;
    logic [10:0]    fh_eff;
    logic [DBW-1:0] kh_eff;
    logic [DBW-1:0] kw_eff;
    logic [KBW-1:0] nk_eff;

    logic [2:0]     state_reg, state_next;
    logic [CW-1:0]  clr_addr_reg;
    logic [CW-1:0]  col_reg;
    logic [9:0]     row_reg;
    logic [LW-1:0]  cur_reg;
    logic [LW-1:0]  cur_lat_reg;
    logic [15:0]    pix_lat_reg;
    logic [9:0]     orow_reg;
    logic [9:0]     ocol_reg;
    logic           emit_reg;
    logic [KIW-1:0] kcnt_reg;
    logic [KBW-1:0] pend_reg;

    logic signed [15:0] win_reg [D][D];
    logic signed [15:0] tap_pix [TAPS];
    logic [15:0]        line_rd [LINES];

    logic                    tv [TAPS+1];
    logic [KIW-1:0]          tk [TAPS+1];
    logic signed [ACC_W-1:0] ts [TAPS+1];

    logic                    out_valid_reg;
    logic [2:0]              kidx_out_reg;
    logic signed [ACC_W-1:0] conv_out_reg;
    logic                    last_out_reg;

    logic acc, pix_acc, coef_acc, coef_ok, adv, inject, clearing, emit;
    logic col_wrap, row_wrap;

    function automatic logic [LW-1:0] slot_of(input logic [LW-1:0] cur, input int i);
        int t;
        t = int'(cur) + LINES - i;
        if (t >= LINES)
        begin
            t = t - LINES;
        end
        return LW'(t);
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= 11'd64;
            fh_reg <= 11'd64;
            kh_reg <= 3'd3;
            kw_reg <= 3'd3;
            nk_reg <= 4'd4;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:    fw_reg <= cfg_data;
                REG_FRAME_HEIGHT:   fh_reg <= cfg_data;
                REG_KERNEL_HEIGHT:  kh_reg <= cfg_data[2:0];
                REG_KERNEL_WIDTH:   kw_reg <= cfg_data[2:0];
                REG_KERNELS_IN_USE: nk_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize saturates
    always_comb
    begin
        if (fw_reg == '0)
            fw_eff = WBW'(1);
        else if (int'(fw_reg) > MAX_WIDTH)
            fw_eff = WBW'(MAX_WIDTH);
        else
            fw_eff = WBW'(fw_reg);

        if (fh_reg == '0)
            fh_eff = 11'd1;
        else if (fh_reg > 11'd1024)
            fh_eff = 11'd1024;
        else
            fh_eff = fh_reg;

        if (kh_reg == '0)
            kh_eff = DBW'(1);
        else if (int'(kh_reg) > D)
            kh_eff = DBW'(D);
        else
            kh_eff = DBW'(kh_reg);

        if (kw_reg == '0)
            kw_eff = DBW'(1);
        else if (int'(kw_reg) > D)
            kw_eff = DBW'(D);
        else
            kw_eff = DBW'(kw_reg);

        if (nk_reg == '0)
            nk_eff = KBW'(1);
        else if (int'(nk_reg) > MAX_KERNELS)
            nk_eff = KBW'(MAX_KERNELS);
        else
            nk_eff = KBW'(nk_reg);
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign acc      = in_valid && in_ready;
    assign pix_acc  = acc && (command == CMD_PIXEL);
    assign coef_acc = acc && (command == CMD_COEF);
    assign coef_ok  = (int'(coef_kernel) < MAX_KERNELS) && (int'(coef_row) < D)
                      && (int'(coef_col) < D);
    assign clearing = (state_reg == ST_CLEAR);
    assign adv      = !out_valid_reg || out_ready;
    assign inject   = (state_reg == ST_INJECT) && adv;

    assign emit     = (int'(row_reg) + 1 >= int'(kh_eff)) && (int'(col_reg) + 1 >= int'(kw_eff));
    assign col_wrap = (int'(col_reg) + 1 >= int'(fw_eff));
    assign row_wrap = (int'(row_reg) + 1 >= int'(fh_eff));

    // controller
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == CW'(MAX_WIDTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (pix_acc)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = emit_reg ? ST_INJECT : ST_IDLE;
            end
            ST_INJECT:
            begin
                if (adv && (int'(kcnt_reg) + 1 == int'(nk_eff)))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (pend_reg == '0)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            cur_reg      <= '0;
            kcnt_reg     <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_addr_reg <= clr_addr_reg + CW'(1);
            if (pix_acc)
            begin
                if (col_wrap)
                begin
                    col_reg <= '0;
                    if (row_wrap)
                    begin
                        row_reg <= '0;
                        cur_reg <= '0;
                    end
                    else
                    begin
                        row_reg <= row_reg + 10'd1;
                        cur_reg <= (int'(cur_reg) == LINES - 1) ? '0 : cur_reg + LW'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (inject)
                kcnt_reg <= (int'(kcnt_reg) + 1 == int'(nk_eff)) ? '0 : kcnt_reg + KIW'(1);
            pend_reg <= pend_reg + KBW'(inject) - KBW'(out_valid_reg && out_ready);
        end
    end

    // per-pixel latches
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            pix_lat_reg <= pixel;
            cur_lat_reg <= cur_reg;
            emit_reg    <= emit;
            orow_reg    <= row_reg - 10'(kh_eff) + 10'd1;
            ocol_reg    <= 10'(col_reg - CW'(kw_eff) + CW'(1));
        end
    end

    // line memories, one per stored row
    for (genvar s = 0; s < LINES; s++)
    begin : g_line
        logic we_s;
        assign we_s = clearing || (pix_acc && (int'(cur_reg) == s));
        mkvc_ram #(
            .WIDTH (16),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk   (clk),
            .we    (we_s),
            .waddr (clearing ? clr_addr_reg : col_reg),
            .wdata (clearing ? 16'd0 : pixel),
            .raddr (col_reg),
            .rdata (line_rd[s])
        );
    end

    // window: shift left, new right column from the line memories and the new pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < D; r++)
                for (int c = 0; c < D; c++)
                    win_reg[r][c] <= '0;
        end
        else if (state_reg == ST_READ)
        begin
            for (int r = 0; r < D; r++)
                for (int c = 0; c + 1 < D; c++)
                    win_reg[r][c] <= win_reg[r][c+1];
            for (int i = 1; i < D; i++)
                if (int'(kh_eff) > i)
                    win_reg[D-1-i][D-1] <= line_rd[slot_of(cur_lat_reg, i)];
            win_reg[D-1][D-1] <= pix_lat_reg;
        end
    end

    // tap (i,j) sees the window anchored at the bottom-right corner
    always_comb
    begin
        for (int i = 0; i < D; i++)
            for (int j = 0; j < D; j++)
                if (i < int'(kh_eff) && j < int'(kw_eff))
                    tap_pix[i*D+j] = win_reg[DW'(D - int'(kh_eff) + i)]
                                            [DW'(D - int'(kw_eff) + j)];
                else
                    tap_pix[i*D+j] = '0;
    end

    assign tv[0] = inject;
    assign tk[0] = kcnt_reg;
    assign ts[0] = '0;

    for (genvar t = 0; t < TAPS; t++)
    begin : g_tap
        logic cwe;
        assign cwe = coef_acc && coef_ok && (int'(coef_row) == t / D)
                     && (int'(coef_col) == t % D);
        mkvc_cell #(
            .KERNELS (MAX_KERNELS),
            .KIW     (KIW)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .adv           (adv),
            .pix           (tap_pix[t]),
            .coef_we       (cwe),
            .coef_kidx     (KIW'(coef_kernel)),
            .coef_val      (coef_value),
            .tok_valid_in  (tv[t]),
            .tok_kidx_in   (tk[t]),
            .psum_in       (ts[t]),
            .tok_valid_out (tv[t+1]),
            .tok_kidx_out  (tk[t+1]),
            .psum_out      (ts[t+1])
        );
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= tv[TAPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kidx_out_reg <= 3'(tk[TAPS]);
            conv_out_reg <= ts[TAPS];
            last_out_reg <= (int'(tk[TAPS]) + 1 == int'(nk_eff));
        end
    end

    assign out_valid    = out_valid_reg;
    assign kernel_index = kidx_out_reg;
    assign out_row      = orow_reg;
    assign out_col      = ocol_reg;
    assign conv_value   = conv_out_reg;
    assign last         = last_out_reg;

`ifndef SYNTHESIS
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> pend_reg == '0)
        else $error("input taken with results in flight");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pend_reg) <= int'(nk_eff))
        else $error("more results in flight than kernels");

    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == ST_INJECT || state_reg == ST_DRAIN))
        else $error("result word outside a pixel's run");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> pend_reg == '0)
        else $error("words left after last");
`endif

endmodule

@@ tb/sv/multi_kernel_valid_conv2d_tb.sv @@
module multi_kernel_valid_conv2d_tb;
    import mkvc_pkg::*;

    localparam int MAX_WIDTH  = 1024;
    localparam int KDIM       = 7;
    localparam int NKERN      = 8;
    localparam int LINES      = KDIM - 1;
    localparam int TAPS       = KDIM * KDIM;
    localparam int DRAIN      = 2 * TAPS + 4 + NKERN + 30;
    localparam int CYCLE_CAP  = 1000000;
    localparam int LONG_HOLD  = 400;

    typedef struct packed {
        logic [2:0]         kern;
        logic [9:0]         row;
        logic [9:0]         col;
        logic signed [37:0] value;
        logic               fin;
    } conv_result_t;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] pix;
        logic [2:0]         kn;
        logic [2:0]         kr;
        logic [2:0]         kc;
        logic signed [15:0] coef;
        logic               typed;
        logic signed [37:0] typed_value;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic command;
    logic signed [15:0] pixel;
    logic [2:0] coef_kernel;
    logic [2:0] coef_row;
    logic [2:0] coef_col;
    logic signed [15:0] coef_value;
    logic out_valid;
    logic out_ready;
    logic [2:0] kernel_index;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic signed [37:0] conv_value;
    logic last;

    multi_kernel_valid_conv2d i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .pixel        (pixel),
        .coef_kernel  (coef_kernel),
        .coef_row     (coef_row),
        .coef_col     (coef_col),
        .coef_value   (coef_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kernel_index (kernel_index),
        .out_row      (out_row),
        .out_col      (out_col),
        .conv_value   (conv_value),
        .last         (last)
    );

    // shadow state of the block
    logic [15:0] line_mem [LINES*MAX_WIDTH];
    logic [15:0] window [TAPS];
    logic [15:0] coef_mem [NKERN*TAPS];
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned reg_fw, reg_fh, reg_kh, reg_kw, reg_nk;

    conv_result_t pending_q[$];
    int errors;
    int cycles;
    bit hold_req;
    bit rx_steady;
    bit tx_steady;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned sat_dim(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void shadow_reset();
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (window[i]) window[i] = '0;
        foreach (coef_mem[i]) coef_mem[i] = '0;
        col_cnt = 0;
        row_cnt = 0;
        reg_fw = 64;
        reg_fh = 64;
        reg_kh = 3;
        reg_kw = 3;
        reg_nk = 4;
    endfunction

    // updates the shadow state for one accepted word and queues its results
    function automatic void convolve_word(stim_row_t w);
        int unsigned fw, fh, kh, kw, nk, col, cur, slot, ocol, orow;
        longint acc;
        conv_result_t res;
        fw = sat_dim(reg_fw, MAX_WIDTH);
        fh = sat_dim(reg_fh, 1024);
        kh = sat_dim(reg_kh, KDIM);
        kw = sat_dim(reg_kw, KDIM);
        nk = sat_dim(reg_nk, NKERN);
        if (w.cmd == CMD_COEF) begin
            if (w.kr < KDIM && w.kc < KDIM)
                coef_mem[w.kn*TAPS + w.kr*KDIM + w.kc] = w.coef;
            return;
        end
        col = col_cnt % MAX_WIDTH;
        cur = row_cnt % LINES;
        for (int i = 0; i < KDIM; i++)
            for (int j = 0; j + 1 < KDIM; j++)
                window[i*KDIM + j] = window[i*KDIM + j + 1];
        for (int i = 1; i < kh; i++) begin
            slot = (cur + LINES - i) % LINES;
            window[(KDIM-1-i)*KDIM + KDIM - 1] = line_mem[slot*MAX_WIDTH + col];
        end
        window[TAPS-1] = w.pix;
        line_mem[cur*MAX_WIDTH + col] = w.pix;
        if (row_cnt + 1 >= kh && col_cnt + 1 >= kw) begin
            orow = row_cnt - (kh - 1);
            ocol = col_cnt - (kw - 1);
            for (int k = 0; k < nk; k++) begin
                acc = 0;
                for (int i = 0; i < kh; i++)
                    for (int j = 0; j < kw; j++)
                        acc += longint'($signed(window[(KDIM-kh+i)*KDIM + KDIM-kw+j]))
                             * longint'($signed(coef_mem[k*TAPS + i*KDIM + j]));
                res.kern  = k[2:0];
                res.row   = orow[9:0];
                res.col   = ocol[9:0];
                res.value = acc[37:0];
                res.fin   = (k + 1 == nk);
                if (w.typed) res.value = w.typed_value;
                pending_q = {pending_q, res};
            end
        end
        col_cnt++;
        if (col_cnt >= fw) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= fh) row_cnt = 0;
        end
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        case (idx)
            REG_FRAME_WIDTH:    reg_fw = val & 11'h7FF;
            REG_FRAME_HEIGHT:   reg_fh = val & 11'h7FF;
            REG_KERNEL_HEIGHT:  reg_kh = val & 3'h7;
            REG_KERNEL_WIDTH:   reg_kw = val & 3'h7;
            REG_KERNELS_IN_USE: reg_nk = val & 4'hF;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic setup_frame(input int unsigned fw, fh, kh, kw, nk);
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_FRAME_HEIGHT, fh);
        write_reg(REG_KERNEL_HEIGHT, kh);
        write_reg(REG_KERNEL_WIDTH, kw);
        write_reg(REG_KERNELS_IN_USE, nk);
    endtask

    // called at a falling edge; valid stays high for a back-to-back word
    task automatic send_word(input stim_row_t w);
        int gap;
        in_valid    <= 1'b1;
        command     <= w.cmd;
        pixel       <= w.pix;
        coef_kernel <= w.kn;
        coef_row    <= w.kr;
        coef_col    <= w.kc;
        coef_value  <= w.coef;
        do @(posedge clk); while (!in_ready);
        convolve_word(w);
        @(negedge clk);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    function automatic stim_row_t random_word();
        stim_row_t w;
        w.cmd  = ($urandom_range(0, 99) < 80) ? CMD_PIXEL : CMD_COEF;
        w.pix  = $urandom;
        w.kn   = $urandom_range(0, 7);
        w.kr   = $urandom_range(0, 7);
        w.kc   = $urandom_range(0, 7);
        w.coef = $urandom;
        w.typed = 1'b0;
        w.typed_value = '0;
        return w;
    endfunction

    // 1x1 kernel, single kernel, 1x1 frame: every pixel is pixel * k0(0,0)
    stim_row_t directed [12] = '{
        '{CMD_COEF,  16'sd0,      3'd0, 3'd0, 3'd0, 16'sd32767,  1'b0, 38'sd0},
        '{CMD_PIXEL, 16'sd32767,  3'd0, 3'd0, 3'd0, 16'sd0,      1'b1, 38'sd1073676289},
        '{CMD_PIXEL, -16'sd32768, 3'd0, 3'd0, 3'd0, 16'sd0,      1'b1, -38'sd1073709056},
        '{CMD_PIXEL, 16'sd0,      3'd0, 3'd0, 3'd0, 16'sd0,      1'b1, 38'sd0},
        '{CMD_COEF,  16'sd0,      3'd0, 3'd0, 3'd0, -16'sd32768, 1'b0, 38'sd0},
        '{CMD_PIXEL, -16'sd32768, 3'd0, 3'd0, 3'd0, 16'sd0,      1'b1, 38'sd1073741824},
        '{CMD_COEF,  16'sd0,      3'd7, 3'd6, 3'd6, 16'sd12345,  1'b0, 38'sd0},
        '{CMD_COEF,  16'sd0,      3'd0, 3'd7, 3'd0, 16'sd5,      1'b0, 38'sd0},
        '{CMD_COEF,  16'sd0,      3'd0, 3'd0, 3'd7, 16'sd5,      1'b0, 38'sd0},
        '{CMD_PIXEL, 16'sd1,      3'd0, 3'd0, 3'd0, 16'sd0,      1'b1, -38'sd32768},
        '{CMD_PIXEL, 16'sh5555,   3'd0, 3'd0, 3'd0, 16'sd0,      1'b0, 38'sd0},
        '{CMD_PIXEL, -16'sh5556,  3'd0, 3'd0, 3'd0, 16'sd0,      1'b0, 38'sd0}
    };

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++)
            send_word(random_word());
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = CMD_PIXEL;
        pixel = '0;
        coef_kernel = '0;
        coef_row = '0;
        coef_col = '0;
        coef_value = '0;
        hold_req = 1'b0;
        rx_steady = 1'b0;
        tx_steady = 1'b0;
        errors = 0;
        shadow_reset();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero registers act as 1
        setup_frame(0, 0, 0, 0, 0);
        foreach (directed[i])
            send_word(directed[i]);
        wait_idle();

        setup_frame(5, 4, 2, 2, 2);
        random_phase(20);

        // back-pressure: sink holds off while the source keeps offering
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        hold_req = 1'b1;
        setup_frame(4, 5, 3, 3, 8);
        random_phase(25);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        setup_frame(7, 8, 7, 7, 8);
        random_phase(50);

        // oversized values saturate
        setup_frame(2047, 2047, 1, 3, 15);
        random_phase(8);

        setup_frame(3, 2, 2, 3, 3);
        random_phase(10);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // sink side
    initial
    begin
        int hold;
        hold = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end else if (!rx_steady && $urandom_range(0, 99) < 30) begin
                out_ready <= 1'b0;
                hold = pick_gap();
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic report(input string field, input logic signed [37:0] exp_v, act_v);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
        errors++;
    endtask

    always @(posedge clk)
    begin
        conv_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got kernel %0d value %0d",
                         $time, kernel_index, conv_value);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (kernel_index !== want.kern) report("kernel_index", want.kern, kernel_index);
                if (out_row !== want.row) report("out_row", want.row, out_row);
                if (out_col !== want.col) report("out_col", want.col, out_col);
                if (conv_value !== want.value) report("conv_value", want.value, conv_value);
                if (last !== want.fin) report("last", want.fin, last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial cycles = 0;

endmodule
